// ===== rtl/ifd_pkg.sv =====
// Shared types, codes and CRC lookup tables for the IMU frame deframer.
`timescale 1ns / 1ps

package ifd_pkg;

    // Frame parser phases, one-hot
    typedef enum logic [4:0] {
        PH_HUNT    = 5'b00001,
        PH_CRC_HI  = 5'b00010,
        PH_CRC_LO  = 5'b00100,
        PH_PAYLOAD = 5'b01000,
        PH_TAIL    = 5'b10000
    } phase_t;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_CRC_GOOD = 2'd1,
        KIND_CRC_BAD  = 2'd2
    } out_kind_t;

    localparam int unsigned HDR_BYTES = 4;

    typedef logic [255:0][7:0]  crc8_tbl_t;
    typedef logic [255:0][15:0] crc16_tbl_t;

    // One byte of CRC-8, reflected polynomial 0x31 (0x8C is 0x31 bit-reversed)
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ 8'h8C) : (c >> 1);
        end
        return c;
    endfunction

    // One byte of CRC-16, polynomial 0x1021, MSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
        end
        return c;
    endfunction

    // CRC-8 contribution of a byte followed by a number of zero bytes
    function automatic crc8_tbl_t crc8_lut_build(input int unsigned zeros);
        crc8_tbl_t  t;
        logic [7:0] c;
        for (int x = 0; x < 256; x++) begin
            c = crc8_byte(8'h00, 8'(x));
            for (int z = 0; z < int'(zeros); z++) begin
                c = crc8_byte(c, 8'h00);
            end
            t[x] = c;
        end
        return t;
    endfunction

    // Byte-wide CRC-16 table
    function automatic crc16_tbl_t crc16_lut_build();
        crc16_tbl_t t;
        for (int x = 0; x < 256; x++) begin
            t[x] = crc16_byte(16'h0000, 8'(x));
        end
        return t;
    endfunction

    // CRC-8 over a four-byte window is the xor of per-position contributions
    localparam crc8_tbl_t  CRC8_AGE0 = crc8_lut_build(0);
    localparam crc8_tbl_t  CRC8_AGE1 = crc8_lut_build(1);
    localparam crc8_tbl_t  CRC8_AGE2 = crc8_lut_build(2);
    localparam crc8_tbl_t  CRC8_AGE3 = crc8_lut_build(3);
    localparam crc16_tbl_t CRC16_TBL = crc16_lut_build();

endpackage

// ===== rtl/imu_frame_deframer_crc8_crc16.sv =====
// Top level of the IMU frame deframer: header hunt, CRC-8 header check, CRC-16 payload check.
//
//  channel   direction  handshake          payload
//  s_        in         s_valid / s_ready  s_in_byte: one received byte per word
//  m_        out        m_valid / m_ready  m_out_kind, m_command, m_payload_byte,
//                                          m_byte_index, m_payload_length
//  cfg_      in         cfg_wr_en          cfg_wr_data: sync byte
//
//  One word per cycle while s_ready is high: each byte is parsed in the cycle it is
//  accepted and its result, if any, lands in the output register at that same edge.
//  Header CRC-8 uses four parallel table lookups; payload CRC-16 one table lookup.
//  A new word is taken whenever the output register is empty or being drained.
//  Reset (aresetn low, synchronous) restores the hunt phase, an empty window,
//  sync byte 0xFC and an empty output register.
`timescale 1ns / 1ps

module imu_frame_deframer_crc8_crc16
    import ifd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_out_kind,
    output logic [7:0] m_command,
    output logic [7:0] m_payload_byte,
    output logic [7:0] m_byte_index,
    output logic [7:0] m_payload_length
);

    // State
    logic [7:0]       sync_byte_reg;
    phase_t           phase_reg,          phase_next;
    logic [3:0][7:0]  header_window_reg,  header_window_next;
    logic [2:0]       window_fill_reg,    window_fill_next;
    logic [7:0]       frame_command_reg,  frame_command_next;
    logic [7:0]       frame_length_reg,   frame_length_next;
    logic [7:0]       payload_count_reg,  payload_count_next;
    logic [15:0]      running_crc_reg,    running_crc_next;
    logic [15:0]      expected_crc_reg,   expected_crc_next;

    // Output register
    logic             m_valid_reg;
    out_kind_t        m_kind_reg,     m_kind_next;
    logic [7:0]       m_command_reg,  m_command_next;
    logic [7:0]       m_data_reg,     m_data_next;
    logic [7:0]       m_index_reg,    m_index_next;
    logic [7:0]       m_length_reg,   m_length_next;
    logic             emit;

    logic             s_fire;
    logic [7:0]       hdr_crc;
    logic             hdr_match;
    logic [7:0]       count_inc;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    // Header CRC-8 over the window, oldest byte first
    assign hdr_crc = CRC8_AGE3[header_window_reg[0]] ^ CRC8_AGE2[header_window_reg[1]]
                   ^ CRC8_AGE1[header_window_reg[2]] ^ CRC8_AGE0[header_window_reg[3]];
    assign hdr_match = (header_window_reg[0] == sync_byte_reg) && (hdr_crc == s_in_byte);

    assign count_inc = payload_count_reg + 8'd1;

    // Parse one word
    always_comb begin
        phase_next         = phase_reg;
        header_window_next = header_window_reg;
        window_fill_next   = window_fill_reg;
        frame_command_next = frame_command_reg;
        frame_length_next  = frame_length_reg;
        payload_count_next = payload_count_reg;
        running_crc_next   = running_crc_reg;
        expected_crc_next  = expected_crc_reg;
        emit               = 1'b0;
        m_kind_next        = KIND_PAYLOAD;
        m_command_next     = frame_command_reg;
        m_data_next        = 8'h00;
        m_index_next       = 8'h00;
        m_length_next      = frame_length_reg;

        unique case (phase_reg)
            PH_HUNT: begin
                if (window_fill_reg < 3'(HDR_BYTES)) begin
                    header_window_next[window_fill_reg[1:0]] = s_in_byte;
                    window_fill_next = window_fill_reg + 3'd1;
                end else if (hdr_match) begin
                    frame_command_next = header_window_reg[1];
                    frame_length_next  = header_window_reg[2];
                    payload_count_next = 8'h00;
                    running_crc_next   = 16'h0000;
                    expected_crc_next  = 16'h0000;
                    phase_next         = PH_CRC_HI;
                end else begin
                    // drop the oldest byte, append the new one
                    header_window_next = {s_in_byte, header_window_reg[3:1]};
                end
            end
            PH_CRC_HI: begin
                expected_crc_next = {s_in_byte, 8'h00};
                phase_next        = PH_CRC_LO;
            end
            PH_CRC_LO: begin
                expected_crc_next = {expected_crc_reg[15:8], s_in_byte};
                phase_next = (frame_length_reg == 8'h00) ? PH_TAIL : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                emit               = 1'b1;
                m_kind_next        = KIND_PAYLOAD;
                m_data_next        = s_in_byte;
                m_index_next       = payload_count_reg;
                running_crc_next   = {running_crc_reg[7:0], 8'h00}
                                   ^ CRC16_TBL[running_crc_reg[15:8] ^ s_in_byte];
                payload_count_next = count_inc;
                if (count_inc >= frame_length_reg) begin
                    phase_next = PH_TAIL;
                end
            end
            PH_TAIL: begin
                emit             = 1'b1;
                m_kind_next      = (running_crc_reg == expected_crc_reg) ?
                                   KIND_CRC_GOOD : KIND_CRC_BAD;
                phase_next       = PH_HUNT;
                window_fill_next = 3'd0;
            end
            default: begin
                phase_next       = PH_HUNT;
                window_fill_next = 3'd0;
            end
        endcase
    end

    // Control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_byte_reg   <= 8'hFC;
            phase_reg       <= PH_HUNT;
            window_fill_reg <= 3'd0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                sync_byte_reg <= cfg_wr_data;
            end
            if (s_fire) begin
                phase_reg       <= phase_next;
                window_fill_reg <= window_fill_next;
                m_valid_reg     <= emit;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Frame data path, advance on each accepted word
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            header_window_reg <= header_window_next;
            frame_command_reg <= frame_command_next;
            frame_length_reg  <= frame_length_next;
            payload_count_reg <= payload_count_next;
            running_crc_reg   <= running_crc_next;
            expected_crc_reg  <= expected_crc_next;
        end
    end

    // Load the result word
    always_ff @(posedge aclk) begin
        if (s_fire && emit) begin
            m_kind_reg    <= m_kind_next;
            m_command_reg <= m_command_next;
            m_data_reg    <= m_data_next;
            m_index_reg   <= m_index_next;
            m_length_reg  <= m_length_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_out_kind       = m_kind_reg;
    assign m_command        = m_command_reg;
    assign m_payload_byte   = m_data_reg;
    assign m_byte_index     = m_index_reg;
    assign m_payload_length = m_length_reg;

    // Checks
    a_end_word_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_out_kind != KIND_PAYLOAD)) |->
            ((m_payload_byte == 8'h00) && (m_byte_index == 8'h00)))
        else $error("frame end word carries payload data");

    a_index_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_out_kind == KIND_PAYLOAD)) |-> (m_byte_index < m_payload_length))
        else $error("payload index beyond frame length");

    a_tail_restarts_hunt: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (phase_reg == PH_TAIL)) |=>
            ((phase_reg == PH_HUNT) && (window_fill_reg == 3'd0) && m_valid
             && (m_out_kind != KIND_PAYLOAD)))
        else $error("tail word did not close the frame");

    a_header_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (phase_reg != PH_PAYLOAD) && (phase_reg != PH_TAIL)) |=> !m_valid)
        else $error("result produced outside payload or tail");

endmodule
